// File: hw/rtl/stmon_pkg.sv
// Shared types, constants and helpers of the stage timing budget monitor.
`timescale 1ns / 1ps

package stmon_pkg;

  localparam int DEF_STAGE_COUNT   = 8;
  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int NUM_BUDGETS       = 8;
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 32;
  localparam int TIME_W            = 32;
  localparam int CNT_W             = 16;
  localparam int STAGE_W           = 3;
  localparam int OP_W              = 2;
  localparam int FILL_OUT_W        = 5;
  localparam int NEXT_OUT_W        = 4;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [CNT_W-1:0] SAT16        = 16'hFFFF;
  localparam logic [CNT_W-1:0] OVERLOAD_RUN = 16'd2;

  localparam logic [OP_W-1:0] OP_TIMING = 2'd0;
  localparam logic [OP_W-1:0] OP_DEFER  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TIMING,
    KIND_DEFER,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [STAGE_W-1:0] stage;
    logic [TIME_W-1:0]  dur;
    logic               over;
    logic [CNT_W-1:0]   dur_sat;
    logic [CNT_W-1:0]   budget_sat;
    logic [TIME_W-1:0]  stamp;
    logic [TIME_W-1:0]  loop_cnt;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]     last_duration;
    logic [TIME_W-1:0]     total_duration;
    logic [TIME_W-1:0]     sample_total;
    logic [TIME_W-1:0]     max_duration;
    logic [CNT_W-1:0]      over_count;
    logic [CNT_W-1:0]      consecutive_over;
    logic [CNT_W-1:0]      max_run;
    logic [CNT_W-1:0]      deferral_count;
    logic                  overloaded;
    logic                  history_pushed;
    logic [FILL_OUT_W-1:0] history_fill;
    logic [NEXT_OUT_W-1:0] history_next;
  } result_t;

  function automatic logic [CNT_W-1:0] sat16(input logic [TIME_W-1:0] v);
    sat16 = (v > TIME_W'(SAT16)) ? SAT16 : v[CNT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/stmon_fifo.sv
// Small first-in first-out queue of packed words.
`timescale 1ns / 1ps

module stmon_fifo import stmon_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             wr_ok, rd_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_ok, rd_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/stmon_front.sv
// Front end: budget registers, duration and over-budget classification of each word.
`timescale 1ns / 1ps

module stmon_front import stmon_pkg::*; #(
  parameter int STAGE_COUNT = DEF_STAGE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  logic [OP_W-1:0]       in_op,
  input  logic [STAGE_W-1:0]    in_stage,
  input  logic [TIME_W-1:0]     in_start_time,
  input  logic [TIME_W-1:0]     in_end_time,
  input  logic [TIME_W-1:0]     in_loop_count,
  input  logic                  q_full,
  output logic                  q_wr,
  output item_t                 q_item
);

  logic [TIME_W-1:0] budget_r [NUM_BUDGETS];
  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] budget;
  logic              stage_ok;
  logic              over;
  kind_t             kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUDGETS; i++) begin
        budget_r[i] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < 32'(NUM_BUDGETS))) begin
      budget_r[cfg_index[STAGE_W-1:0]] <= cfg_wdata[TIME_W-1:0];
    end
  end

  always_comb begin
    dur      = in_end_time - in_start_time;
    budget   = budget_r[in_stage];
    over     = dur > budget;
    stage_ok = 32'(in_stage) < 32'(STAGE_COUNT);
    unique case (in_op)
      OP_TIMING: kind = KIND_TIMING;
      OP_DEFER:  kind = KIND_DEFER;
      default:   kind = KIND_QUERY;
    endcase
    if (!stage_ok) begin
      kind = KIND_NONE;
    end
  end

  always_comb begin
    q_item.kind       = kind;
    q_item.stage      = in_stage;
    q_item.dur        = dur;
    q_item.over       = over;
    q_item.dur_sat    = sat16(dur);
    q_item.budget_sat = sat16(budget);
    q_item.stamp      = in_end_time;
    q_item.loop_cnt   = in_loop_count;
  end

  assign q_wr = in_push && !q_full;

endmodule

// File: hw/rtl/stmon_back.sv
// Back end: per-stage statistics read-modify-write, history ring and result build.
`timescale 1ns / 1ps

module stmon_back import stmon_pkg::*; #(
  parameter int STAGE_COUNT   = DEF_STAGE_COUNT,
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  item_t   q_item,
  output logic    q_rd,
  input  logic    out_full,
  output logic    r_wr,
  output result_t r_data
);

  localparam int SIW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int HNW = $clog2(HISTORY_DEPTH);
  localparam int HFW = $clog2(HISTORY_DEPTH + 1);
  localparam int HT_W = 2 * TIME_W;
  localparam int HI_W = 2 * CNT_W + 2 + STAGE_W;

  logic [TIME_W-1:0] last_r    [STAGE_COUNT];
  logic [TIME_W-1:0] total_r   [STAGE_COUNT];
  logic [TIME_W-1:0] samples_r [STAGE_COUNT];
  logic [TIME_W-1:0] max_r     [STAGE_COUNT];
  logic [CNT_W-1:0]  over_r    [STAGE_COUNT];
  logic [CNT_W-1:0]  consec_r  [STAGE_COUNT];
  logic [CNT_W-1:0]  max_run_r [STAGE_COUNT];
  logic [CNT_W-1:0]  defer_r   [STAGE_COUNT];

  logic [HT_W-1:0] hist_times_r [HISTORY_DEPTH];
  logic [HI_W-1:0] hist_info_r  [HISTORY_DEPTH];
  logic [HNW-1:0]  next_r, next_nxt;
  logic [HFW-1:0]  fill_r, fill_nxt;

  logic [SIW-1:0]    idx;
  logic              go;
  logic              upd;
  logic              push;
  logic [TIME_W-1:0] last_nxt, total_nxt, samples_nxt, max_nxt;
  logic [CNT_W-1:0]  over_nxt, consec_nxt, max_run_nxt, defer_nxt;
  logic [CNT_W-1:0]  hist_dur;
  logic [31:0]       fill_ext, next_ext;

  assign idx  = q_item.stage[SIW-1:0];
  assign go   = !q_empty && !out_full;
  assign q_rd = go;
  assign r_wr = go;

  always_comb begin
    last_nxt    = last_r[idx];
    total_nxt   = total_r[idx];
    samples_nxt = samples_r[idx];
    max_nxt     = max_r[idx];
    over_nxt    = over_r[idx];
    consec_nxt  = consec_r[idx];
    max_run_nxt = max_run_r[idx];
    defer_nxt   = defer_r[idx];
    upd         = 1'b0;
    push        = 1'b0;
    hist_dur    = '0;
    case (q_item.kind)
      KIND_TIMING: begin
        upd         = 1'b1;
        last_nxt    = q_item.dur;
        total_nxt   = total_r[idx] + q_item.dur;
        samples_nxt = samples_r[idx] + 1'b1;
        if (q_item.dur > max_r[idx]) begin
          max_nxt = q_item.dur;
        end
        if (q_item.over) begin
          push     = 1'b1;
          hist_dur = q_item.dur_sat;
          if (over_r[idx] != SAT16) begin
            over_nxt = over_r[idx] + 1'b1;
          end
          if (consec_r[idx] != SAT16) begin
            consec_nxt = consec_r[idx] + 1'b1;
          end
          if (consec_nxt > max_run_r[idx]) begin
            max_run_nxt = consec_nxt;
          end
        end else begin
          consec_nxt = '0;
        end
      end
      KIND_DEFER: begin
        upd  = 1'b1;
        push = 1'b1;
        if (defer_r[idx] != SAT16) begin
          defer_nxt = defer_r[idx] + 1'b1;
        end
      end
      default: begin
      end
    endcase

    next_nxt = next_r;
    fill_nxt = fill_r;
    if (push) begin
      next_nxt = (next_r == HNW'(HISTORY_DEPTH - 1)) ? '0 : next_r + 1'b1;
      if (fill_r != HFW'(HISTORY_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    fill_ext = 32'(fill_nxt);
    next_ext = 32'(next_nxt);
  end

  always_comb begin
    r_data = '0;
    if (q_item.kind != KIND_NONE) begin
      r_data.last_duration    = last_nxt;
      r_data.total_duration   = total_nxt;
      r_data.sample_total     = samples_nxt;
      r_data.max_duration     = max_nxt;
      r_data.over_count       = over_nxt;
      r_data.consecutive_over = consec_nxt;
      r_data.max_run          = max_run_nxt;
      r_data.deferral_count   = defer_nxt;
      r_data.overloaded       = consec_nxt >= OVERLOAD_RUN;
      r_data.history_pushed   = push;
      r_data.history_fill     = fill_ext[FILL_OUT_W-1:0];
      r_data.history_next     = next_ext[NEXT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGE_COUNT; i++) begin
        last_r[i]    <= '0;
        total_r[i]   <= '0;
        samples_r[i] <= '0;
        max_r[i]     <= '0;
        over_r[i]    <= '0;
        consec_r[i]  <= '0;
        max_run_r[i] <= '0;
        defer_r[i]   <= '0;
      end
      next_r <= '0;
      fill_r <= '0;
    end else if (go) begin
      if (upd) begin
        last_r[idx]    <= last_nxt;
        total_r[idx]   <= total_nxt;
        samples_r[idx] <= samples_nxt;
        max_r[idx]     <= max_nxt;
        over_r[idx]    <= over_nxt;
        consec_r[idx]  <= consec_nxt;
        max_run_r[idx] <= max_run_nxt;
        defer_r[idx]   <= defer_nxt;
      end
      next_r <= next_nxt;
      fill_r <= fill_nxt;
    end
  end

  // history ring: time stamp / loop count, and duration, budget, flags, stage
  always_ff @(posedge clk) begin
    if (go && push) begin
      hist_times_r[next_r] <= {q_item.loop_cnt, q_item.stamp};
      hist_info_r[next_r]  <= {q_item.stage, (q_item.kind == KIND_DEFER),
                               (q_item.kind == KIND_TIMING), q_item.budget_sat, hist_dur};
    end
  end

endmodule

// File: hw/rtl/stage_timing_budget_monitor.sv
// Top level of the stage timing budget monitor.
`timescale 1ns / 1ps

// Takes one word per cycle while full is low and returns one result word per input
// word, in order. Words wait in the item queue; the back end updates the addressed
// stage's statistics registers by read-modify-write and writes the result into the
// result queue, whose head drives out_; the back end stalls while it is full. With
// pop held low the result queue holds two words and the item queue two more, then
// full rises. Budgets are to be written through cfg_ while idle (not enforced).
// Indexes above 7 are ignored. Stages at or above STAGE_COUNT return all zeros.
module stage_timing_budget_monitor import stmon_pkg::*; #(
  parameter int STAGE_COUNT   = DEF_STAGE_COUNT,
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  logic [OP_W-1:0]       in_op,
  input  logic [STAGE_W-1:0]    in_stage,
  input  logic [TIME_W-1:0]     in_start_time,
  input  logic [TIME_W-1:0]     in_end_time,
  input  logic [TIME_W-1:0]     in_loop_count,
  output logic                  empty,
  input  logic                  pop,
  output logic [TIME_W-1:0]     out_last_duration,
  output logic [TIME_W-1:0]     out_total_duration,
  output logic [TIME_W-1:0]     out_sample_total,
  output logic [TIME_W-1:0]     out_max_duration,
  output logic [CNT_W-1:0]      out_over_count,
  output logic [CNT_W-1:0]      out_consecutive_over,
  output logic [CNT_W-1:0]      out_max_run,
  output logic [CNT_W-1:0]      out_deferral_count,
  output logic                  out_overloaded,
  output logic                  out_history_pushed,
  output logic [FILL_OUT_W-1:0] out_history_fill,
  output logic [NEXT_OUT_W-1:0] out_history_next
);

  item_t   fq_wr_item, fq_rd_item;
  logic    fq_wr, fq_full, fq_rd, fq_empty;
  result_t rq_wr_data, rq_rd_data;
  logic    rq_wr, rq_full;

  stmon_front #(
    .STAGE_COUNT(STAGE_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (push),
    .in_op        (in_op),
    .in_stage     (in_stage),
    .in_start_time(in_start_time),
    .in_end_time  (in_end_time),
    .in_loop_count(in_loop_count),
    .q_full       (fq_full),
    .q_wr         (fq_wr),
    .q_item       (fq_wr_item)
  );

  stmon_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_item_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fq_wr),
    .wr_data(fq_wr_item),
    .full   (fq_full),
    .rd_en  (fq_rd),
    .rd_data(fq_rd_item),
    .empty  (fq_empty)
  );

  stmon_back #(
    .STAGE_COUNT  (STAGE_COUNT),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (fq_empty),
    .q_item  (fq_rd_item),
    .q_rd    (fq_rd),
    .out_full(rq_full),
    .r_wr    (rq_wr),
    .r_data  (rq_wr_data)
  );

  stmon_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rq_wr),
    .wr_data(rq_wr_data),
    .full   (rq_full),
    .rd_en  (pop),
    .rd_data(rq_rd_data),
    .empty  (empty)
  );

  assign full                 = fq_full;
  assign out_last_duration    = rq_rd_data.last_duration;
  assign out_total_duration   = rq_rd_data.total_duration;
  assign out_sample_total     = rq_rd_data.sample_total;
  assign out_max_duration     = rq_rd_data.max_duration;
  assign out_over_count       = rq_rd_data.over_count;
  assign out_consecutive_over = rq_rd_data.consecutive_over;
  assign out_max_run          = rq_rd_data.max_run;
  assign out_deferral_count   = rq_rd_data.deferral_count;
  assign out_overloaded       = rq_rd_data.overloaded;
  assign out_history_pushed   = rq_rd_data.history_pushed;
  assign out_history_fill     = rq_rd_data.history_fill;
  assign out_history_next     = rq_rd_data.history_next;

  a_overload_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_overloaded == (out_consecutive_over >= OVERLOAD_RUN)))
    else $error("overload flag disagrees with consecutive count");

  a_back_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fq_rd |-> !rq_full)
    else $error("back end wrote a full result queue");

  a_word_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> !fq_empty)
    else $error("accepted word missing from item queue");

endmodule

// File: dv/tb_stage_timing_budget_monitor.sv
// Self-checking testbench for the stage timing budget monitor: directed table, then random words.
`timescale 1ns / 1ps

module tb_stage_timing_budget_monitor import stmon_pkg::*;;

  localparam int STAGES = DEF_STAGE_COUNT;
  localparam int RING_DEPTH = DEF_HISTORY_DEPTH;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(NUM_BUDGETS);
  localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_IDX = '1;
  localparam int PHASES = 4;
  localparam int WORDS_PER_PHASE = 282;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [STAGE_W-1:0] stage;
    logic [TIME_W-1:0]  t_start;
    logic [TIME_W-1:0]  t_end;
    logic [TIME_W-1:0]  loop_no;
  } timing_word_t;

  typedef struct {
    timing_word_t w;
    bit           known;
    result_t      want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [OP_W-1:0]       in_op = '0;
  logic [STAGE_W-1:0]    in_stage = '0;
  logic [TIME_W-1:0]     in_start_time = '0;
  logic [TIME_W-1:0]     in_end_time = '0;
  logic [TIME_W-1:0]     in_loop_count = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [TIME_W-1:0]     out_last_duration;
  logic [TIME_W-1:0]     out_total_duration;
  logic [TIME_W-1:0]     out_sample_total;
  logic [TIME_W-1:0]     out_max_duration;
  logic [CNT_W-1:0]      out_over_count;
  logic [CNT_W-1:0]      out_consecutive_over;
  logic [CNT_W-1:0]      out_max_run;
  logic [CNT_W-1:0]      out_deferral_count;
  logic                  out_overloaded;
  logic                  out_history_pushed;
  logic [FILL_OUT_W-1:0] out_history_fill;
  logic [NEXT_OUT_W-1:0] out_history_next;

  // predictor state
  logic [TIME_W-1:0] budget_reg [NUM_BUDGETS] = '{default: '0};
  logic [TIME_W-1:0] st_last [STAGES] = '{default: '0};
  logic [TIME_W-1:0] st_total [STAGES] = '{default: '0};
  logic [TIME_W-1:0] st_samples [STAGES] = '{default: '0};
  logic [TIME_W-1:0] st_peak [STAGES] = '{default: '0};
  logic [CNT_W-1:0]  st_over [STAGES] = '{default: '0};
  logic [CNT_W-1:0]  st_run [STAGES] = '{default: '0};
  logic [CNT_W-1:0]  st_best_run [STAGES] = '{default: '0};
  logic [CNT_W-1:0]  st_defer [STAGES] = '{default: '0};
  int                ring_next = 0;
  int                ring_fill = 0;

  logic [TIME_W-1:0] budget_plan [NUM_BUDGETS];
  result_t           stats_due [$];
  dir_row_t          directed_rows [$];
  bit                calm = 1'b0;
  int                last_stage = 0;
  int                mismatches = 0;
  int                words_sent = 0;
  int                results_checked = 0;
  int                ring_writes = 0;
  int                overload_hits = 0;

  stage_timing_budget_monitor dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .push                 (push),
    .full                 (full),
    .in_op                (in_op),
    .in_stage             (in_stage),
    .in_start_time        (in_start_time),
    .in_end_time          (in_end_time),
    .in_loop_count        (in_loop_count),
    .empty                (empty),
    .pop                  (pop),
    .out_last_duration    (out_last_duration),
    .out_total_duration   (out_total_duration),
    .out_sample_total     (out_sample_total),
    .out_max_duration     (out_max_duration),
    .out_over_count       (out_over_count),
    .out_consecutive_over (out_consecutive_over),
    .out_max_run          (out_max_run),
    .out_deferral_count   (out_deferral_count),
    .out_overloaded       (out_overloaded),
    .out_history_pushed   (out_history_pushed),
    .out_history_fill     (out_history_fill),
    .out_history_next     (out_history_next)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic result_t account_word(input timing_word_t w);
    result_t           r;
    logic [TIME_W-1:0] dur;
    int                s;
    logic              wrote;
    r = '0;
    wrote = 1'b0;
    s = int'(w.stage);
    if (s >= STAGES) return r;
    dur = w.t_end - w.t_start;
    case (w.op)
      OP_TIMING: begin
        st_last[s] = dur;
        st_total[s] = st_total[s] + dur;
        st_samples[s] = st_samples[s] + 1'b1;
        if (dur > st_peak[s]) st_peak[s] = dur;
        if (dur > budget_reg[s]) begin
          if (st_over[s] != SAT16) st_over[s] = st_over[s] + 1'b1;
          if (st_run[s] != SAT16) st_run[s] = st_run[s] + 1'b1;
          if (st_run[s] > st_best_run[s]) st_best_run[s] = st_run[s];
          wrote = 1'b1;
        end else begin
          st_run[s] = '0;
        end
      end
      OP_DEFER: begin
        if (st_defer[s] != SAT16) st_defer[s] = st_defer[s] + 1'b1;
        wrote = 1'b1;
      end
      default: ;
    endcase
    if (wrote) begin
      ring_next = (ring_next + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
    end
    r.last_duration = st_last[s];
    r.total_duration = st_total[s];
    r.sample_total = st_samples[s];
    r.max_duration = st_peak[s];
    r.over_count = st_over[s];
    r.consecutive_over = st_run[s];
    r.max_run = st_best_run[s];
    r.deferral_count = st_defer[s];
    r.overloaded = (st_run[s] >= OVERLOAD_RUN);
    r.history_pushed = wrote;
    r.history_fill = FILL_OUT_W'(ring_fill);
    r.history_next = NEXT_OUT_W'(ring_next);
    return r;
  endfunction

  // half the time stays on the previous stage so over-budget runs build up
  function automatic timing_word_t random_word();
    timing_word_t      w;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] dur;
    int                pick;
    if ($urandom_range(0, 1) == 0) last_stage = $urandom_range(0, STAGES - 1);
    w.stage = STAGE_W'(last_stage);
    pick = $urandom_range(0, 99);
    if (pick < 55) w.op = OP_TIMING;
    else if (pick < 75) w.op = OP_DEFER;
    else if (pick < 93) w.op = OP_QUERY;
    else w.op = OP_SPARE;
    w.t_start = $urandom();
    w.t_end = $urandom();
    w.loop_no = $urandom();
    b = budget_reg[last_stage];
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      dur = $urandom_range(b, 0);
    end else if (pick < 8) begin
      if (b == '1) begin
        dur = '1;
      end else begin
        span = 32'hFFFF_FFFE - b;
        if (span > 3000) span = 3000;
        dur = b + 1 + $urandom_range(span, 0);
      end
    end else if (pick == 8) begin
      dur = b;
    end else begin
      dur = w.t_end - w.t_start;
    end
    w.t_end = w.t_start + dur;
    return w;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input int stage,
                                  input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1,
                                  input logic [TIME_W-1:0] loop_no, input bit known,
                                  input result_t want);
    dir_row_t row;
    row.w.op = op;
    row.w.stage = STAGE_W'(stage);
    row.w.t_start = t0;
    row.w.t_end = t1;
    row.w.loop_no = loop_no;
    row.known = known;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic send_word(input timing_word_t w, input bit known, input result_t want);
    result_t predicted;
    if (!calm && $urandom_range(0, 99) < 11) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    push <= 1'b1;
    in_op <= w.op;
    in_stage <= w.stage;
    in_start_time <= w.t_start;
    in_end_time <= w.t_end;
    in_loop_count <= w.loop_no;
    do @(posedge clk); while (full);
    predicted = account_word(w);
    stats_due.push_back(known ? want : predicted);
    words_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_budgets(input logic [CFG_IDX_W-1:0] stray_idx,
                              input logic [CFG_DATA_W-1:0] stray_data);
    for (int i = 0; i < NUM_BUDGETS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= budget_plan[i];
      @(posedge clk);
      budget_reg[i] = budget_plan[i];
    end
    // index past the budget bank: must be dropped
    cfg_index <= stray_idx;
    cfg_wdata <= stray_data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, msg);
  endtask

  task automatic cmp_field(input string name, input logic [TIME_W-1:0] got,
                           input logic [TIME_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (stats_due.size() == 0) begin
      report_mismatch("result word with nothing outstanding");
    end else begin
      want = stats_due.pop_front();
      cmp_field("last_duration", out_last_duration, want.last_duration);
      cmp_field("total_duration", out_total_duration, want.total_duration);
      cmp_field("sample_total", out_sample_total, want.sample_total);
      cmp_field("max_duration", out_max_duration, want.max_duration);
      cmp_field("over_count", TIME_W'(out_over_count), TIME_W'(want.over_count));
      cmp_field("consecutive_over", TIME_W'(out_consecutive_over),
                TIME_W'(want.consecutive_over));
      cmp_field("max_run", TIME_W'(out_max_run), TIME_W'(want.max_run));
      cmp_field("deferral_count", TIME_W'(out_deferral_count), TIME_W'(want.deferral_count));
      cmp_field("overloaded", TIME_W'(out_overloaded), TIME_W'(want.overloaded));
      cmp_field("history_pushed", TIME_W'(out_history_pushed), TIME_W'(want.history_pushed));
      cmp_field("history_fill", TIME_W'(out_history_fill), TIME_W'(want.history_fill));
      cmp_field("history_next", TIME_W'(out_history_next), TIME_W'(want.history_next));
      if (want.history_pushed) ring_writes++;
      if (want.overloaded) overload_hits++;
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_result();
  end

  initial begin
    // result order: last, total, samples, max, over, consec, max_run, deferred,
    // overloaded, pushed, fill, next
    add_row(OP_QUERY, 0, '0, '0, '0, 1'b1, '0);
    add_row(OP_SPARE, 7, '1, '1, '1, 1'b1, '0);
    add_row(OP_TIMING, 1, '0, '1, '1, 1'b1,
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
              16'd1, 16'd1, 16'd1, 16'd0, 1'b0, 1'b1, 5'd1, 4'd1});
    // end before start wraps to the largest duration
    add_row(OP_TIMING, 1, 32'd1, 32'd0, '0, 1'b1,
            '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFF,
              16'd2, 16'd2, 16'd2, 16'd0, 1'b1, 1'b1, 5'd2, 4'd2});
    add_row(OP_TIMING, 1, 32'd5, 32'd5, 32'd3, 1'b1,
            '{32'd0, 32'hFFFF_FFFE, 32'd3, 32'hFFFF_FFFF,
              16'd2, 16'd0, 16'd2, 16'd0, 1'b0, 1'b0, 5'd2, 4'd2});
    add_row(OP_DEFER, 7, '0, '1, 32'hAAAA_AAAA, 1'b1,
            '{32'd0, 32'd0, 32'd0, 32'd0,
              16'd0, 16'd0, 16'd0, 16'd1, 1'b0, 1'b1, 5'd3, 4'd3});
    add_row(OP_TIMING, 0, '0, '0, 32'h5555_5555, 1'b0, '0);
    add_row(OP_TIMING, 2, 32'h8000_0000, 32'h7FFF_FFFF, '1, 1'b0, '0);
    add_row(OP_TIMING, 3, 32'd1, 32'd2, 32'd7, 1'b0, '0);
    add_row(OP_TIMING, 4, '1, '0, 32'd9, 1'b0, '0);
    add_row(OP_TIMING, 5, '0, 32'h5555_5555, 32'h5555_5555, 1'b0, '0);
    add_row(OP_TIMING, 6, 32'hAAAA_AAAA, '0, 32'hAAAA_AAAA, 1'b0, '0);
    // enough deferrals to fill the ring and wrap its write pointer
    for (int i = 0; i < 12; i++)
      add_row(OP_DEFER, i % STAGES, $urandom(), $urandom(), i, 1'b0, '0);
    add_row(OP_QUERY, 1, '1, '0, '0, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i].w, directed_rows[i].known,
                                         directed_rows[i].want);
    drain();
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        budget_plan = '{32'd0, 32'd1, 32'h0000_FFFF, 32'h0001_0000,
                        32'd1000, 32'd5000, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
        load_budgets(LAST_UNUSED_IDX, '1);
      end else begin
        foreach (budget_plan[i]) begin
          case ($urandom_range(0, 9))
            0: budget_plan[i] = '0;
            1: budget_plan[i] = '1;
            2: budget_plan[i] = $urandom();
            default: budget_plan[i] = $urandom_range(4000, 0);
          endcase
        end
        load_budgets(CFG_IDX_W'($urandom_range(LAST_UNUSED_IDX, FIRST_UNUSED_IDX)),
                     $urandom());
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        calm = (ph == 2) && (n >= 50) && (n < 250);
        if (ph == 1 && n == 140) drain();
        send_word(random_word(), 1'b0, '0);
      end
      calm = 1'b0;
      drain();
      @(posedge clk);
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d words over %0d budget settings, checked %0d results.",
             words_sent, PHASES + 1, results_checked);
    $display("Ring writes seen: %0d, overloaded results seen: %0d.",
             ring_writes, overload_hits);
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
